@@ hw/rtl/ntfs_data_run_decoder_assert.svh @@
// assertion helpers for the decoder rtl
`ifndef NTFS_DATA_RUN_DECODER_ASSERT_SVH
`define NTFS_DATA_RUN_DECODER_ASSERT_SVH

// plain property, checked on every rising clock edge outside reset
`define NDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define NDR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/ndr_pkg.sv @@
package ndr_pkg;

  localparam int unsigned LIST_BYTE_W = 8;
  localparam int unsigned SECTOR_W    = 64;
  localparam int unsigned VOL_W       = 48;
  localparam int unsigned SPC_W       = 8;
  localparam int unsigned NEED_W      = 46;
  localparam int unsigned CFG_W       = 48;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FSIZE_W     = 4;
  localparam int unsigned ACC_STEPS   = 8;
  localparam int unsigned STEP_W      = 3;

  localparam int unsigned SECTOR_BYTES_DEF    = 512;
  localparam int unsigned MAX_FIELD_BYTES_DEF = 8;

  localparam logic [SPC_W-1:0]  SPC_RESET = 8'd8;
  localparam logic [NEED_W-1:0] COV_MAX   = 46'h3FFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOL_START = 2'd0,
    CFG_SPC       = 2'd1,
    CFG_NEED      = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OUTCOME_RUN       = 3'd0,
    OUTCOME_END       = 3'd1,
    OUTCOME_ZERO_LEN  = 3'd2,
    OUTCOME_OVERSIZE  = 3'd3,
    OUTCOME_TRUNCATED = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [LIST_BYTE_W-1:0] list_byte;
    logic                   first_of_list;
    logic                   last_of_list;
  } in_beat_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] run_start_sector;
    logic [SECTOR_W-1:0] run_sector_count;
    logic                is_sparse;
    outcome_e            outcome;
    logic                bitmap_complete;
  } out_beat_t;

  // parsed run handed to the sector arithmetic
  typedef struct packed {
    logic [SECTOR_W-1:0] run_len;
    logic [SECTOR_W-1:0] cluster;
    logic                use_start;
    logic                is_sparse;
    outcome_e            outcome;
    logic                bitmap_complete;
  } calc_t;

endpackage

@@ hw/rtl/ntfs_data_run_decoder.sv @@
// channel  dir  handshake                 beat
// in       in   in_valid_i / in_ready_o   ndr_pkg::in_beat_t, one run-list byte
// out      out  out_valid_o / out_ready_i ndr_pkg::out_beat_t, at most one per input beat
// cfg      in   cfg_we_i                  cfg_index_i selects, cfg_data_i carries the value
// one input beat per cycle while in_ready_o is high; a result passes the parse, multiply and add stage registers
// the byte parse and the saturating coverage sum close in the same cycle as the beat
// a write to sectors_per_cluster re-sums coverage of the open run byte by byte, in_ready_o low until done
// reset: volume start 0, 8 sectors per cluster, nothing needed, parser at a header
// a stalled output fills three stage registers before in_ready_o drops
module ntfs_data_run_decoder #(
  parameter int unsigned SECTOR_BYTES    = ndr_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned MAX_FIELD_BYTES = ndr_pkg::MAX_FIELD_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ndr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ndr_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ndr_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ndr_pkg::out_beat_t              out_data_o
);

  `include "ntfs_data_run_decoder_assert.svh"

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } phase_e;

  localparam int unsigned UNIT_W  = ndr_pkg::SPC_W + $clog2(SECTOR_BYTES + 1);
  localparam int unsigned TERM_W  = ndr_pkg::LIST_BYTE_W + UNIT_W;
  localparam int unsigned SHIFT_W = TERM_W + (ndr_pkg::ACC_STEPS - 1) * 8;
  localparam int unsigned NW      = ndr_pkg::NEED_W;
  localparam int unsigned SW      = ndr_pkg::SECTOR_W;
  localparam logic [ndr_pkg::FSIZE_W-1:0] MAX_FB  = ndr_pkg::FSIZE_W'(MAX_FIELD_BYTES);
  localparam logic [ndr_pkg::FSIZE_W-1:0] FULL_FB = ndr_pkg::FSIZE_W'(8);
  localparam logic [ndr_pkg::STEP_W-1:0]  STEP_LAST =
      ndr_pkg::STEP_W'(ndr_pkg::ACC_STEPS - 1);
  localparam logic [UNIT_W-1:0] UNIT_RESET =
      UNIT_W'(int'(ndr_pkg::SPC_RESET) * SECTOR_BYTES);

  // configuration
  logic [ndr_pkg::VOL_W-1:0]  vol_q, vol_d;
  logic [ndr_pkg::SPC_W-1:0]  spc_q, spc_d;
  logic [NW-1:0]              need_q, need_d;
  logic [UNIT_W-1:0]          unit_q, unit_d;

  // parser state
  phase_e                       phase_q, phase_d;
  logic [ndr_pkg::FSIZE_W-1:0]  idx_q, idx_d, lsz_q, lsz_d, osz_q, osz_d;
  logic [SW-1:0]                rl_q, rl_d, off_q, off_d, rc_q, rc_d;
  logic [NW-1:0]                cov_q, cov_d, acc_q, acc_d;
  logic                         sticky_q, sticky_d, stopped_q, stopped_d;
  logic                         busy_q, busy_d;
  logic [ndr_pkg::STEP_W-1:0]   step_q, step_d;

  // working values
  logic                         accept, calc_ready;
  logic [7:0]                   b;
  logic                         last;
  phase_e                       c_phase;
  logic [ndr_pkg::FSIZE_W-1:0]  c_idx, idx_new;
  logic [SW-1:0]                c_rl, c_off, c_rc, off_new, ext;
  logic [NW-1:0]                c_cov, cov_fin;
  logic                         c_stopped;
  logic [7:0]                   acc_byte;
  logic [2:0]                   acc_sh;
  logic [TERM_W-1:0]            term;
  logic [SHIFT_W-1:0]           shifted;
  logic [NW:0]                  sum_w;
  logic [NW-1:0]                acc_sum;
  logic                         acc_sticky;
  logic                         do_halt, do_finish, fin_sparse, complete;
  ndr_pkg::outcome_e            halt_code;
  ndr_pkg::calc_t               res_d;
  logic                         res_valid;

  assign b    = in_data_i.list_byte;
  assign last = in_data_i.last_of_list;

  assign in_ready_o = calc_ready && !busy_q && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  // shared byte-times-cluster-bytes adder for coverage
  assign acc_byte = busy_q ? rl_q[{step_q, 3'b000} +: 8] : b;
  assign acc_sh   = busy_q ? step_q : c_idx[2:0];
  assign term     = {{UNIT_W{1'b0}}, acc_byte} * {{ndr_pkg::LIST_BYTE_W{1'b0}}, unit_q};
  assign shifted  = SHIFT_W'(term) << {acc_sh, 3'b000};
  assign sum_w    = {1'b0, acc_q} + {1'b0, shifted[NW-1:0]};
  assign acc_sum  = sum_w[NW-1:0];
  assign acc_sticky = sticky_q || (|shifted[SHIFT_W-1:NW]) || sum_w[NW];

  always_comb begin
    vol_d  = vol_q;
    spc_d  = spc_q;
    need_d = need_q;
    unit_d = unit_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ndr_pkg::CFG_VOL_START: begin
          vol_d = cfg_data_i[ndr_pkg::VOL_W-1:0];
        end
        ndr_pkg::CFG_SPC: begin
          spc_d  = cfg_data_i[ndr_pkg::SPC_W-1:0];
          unit_d = {{(UNIT_W - ndr_pkg::SPC_W){1'b0}}, cfg_data_i[ndr_pkg::SPC_W-1:0]} *
                   UNIT_W'(SECTOR_BYTES);
        end
        ndr_pkg::CFG_NEED: begin
          need_d = cfg_data_i[NW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    // a first beat clears the list state before it is parsed
    if (in_data_i.first_of_list) begin
      c_phase   = PH_HEADER;
      c_idx     = '0;
      c_rl      = '0;
      c_off     = '0;
      c_rc      = '0;
      c_cov     = '0;
      c_stopped = 1'b0;
    end else begin
      c_phase   = phase_q;
      c_idx     = idx_q;
      c_rl      = rl_q;
      c_off     = off_q;
      c_rc      = rc_q;
      c_cov     = cov_q;
      c_stopped = stopped_q;
    end

    phase_d    = phase_q;
    idx_d      = idx_q;
    lsz_d      = lsz_q;
    osz_d      = osz_q;
    rl_d       = rl_q;
    off_d      = off_q;
    rc_d       = rc_q;
    cov_d      = cov_q;
    stopped_d  = stopped_q;
    acc_d      = acc_q;
    sticky_d   = sticky_q;
    busy_d     = busy_q;
    step_d     = step_q;
    idx_new    = c_idx + 4'd1;
    off_new    = c_off | (SW'(b) << {c_idx[2:0], 3'b000});
    ext        = off_new;
    do_halt    = 1'b0;
    do_finish  = 1'b0;
    fin_sparse = 1'b0;
    halt_code  = ndr_pkg::OUTCOME_END;
    cov_fin    = c_cov;
    complete   = 1'b0;
    res_valid  = 1'b0;
    res_d      = '0;

    if (busy_q) begin
      acc_d    = acc_sum;
      sticky_d = acc_sticky;
      step_d   = step_q + 3'd1;
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
      end
    end
    if (cfg_we_i && cfg_index_i == ndr_pkg::CFG_SPC) begin
      busy_d   = 1'b1;
      step_d   = '0;
      acc_d    = cov_q;
      sticky_d = 1'b0;
    end

    if (accept) begin
      phase_d   = c_phase;
      idx_d     = c_idx;
      rl_d      = c_rl;
      off_d     = c_off;
      rc_d      = c_rc;
      cov_d     = c_cov;
      stopped_d = c_stopped;
      if (in_data_i.first_of_list) begin
        lsz_d = '0;
        osz_d = '0;
      end
      if (!c_stopped) begin
        case (c_phase)
          PH_HEADER: begin
            if (c_cov >= need_q || b == 8'h00) begin
              do_halt   = 1'b1;
              halt_code = ndr_pkg::OUTCOME_END;
            end else begin
              lsz_d = b[3:0];
              osz_d = b[7:4];
              if (b[3:0] == 4'h0) begin
                do_halt   = 1'b1;
                halt_code = ndr_pkg::OUTCOME_ZERO_LEN;
              end else if (b[3:0] > MAX_FB || b[7:4] > MAX_FB) begin
                do_halt   = 1'b1;
                halt_code = ndr_pkg::OUTCOME_OVERSIZE;
              end else begin
                rl_d     = '0;
                off_d    = '0;
                idx_d    = '0;
                phase_d  = PH_LENGTH;
                acc_d    = c_cov;
                sticky_d = 1'b0;
                if (last) begin
                  do_halt   = 1'b1;
                  halt_code = ndr_pkg::OUTCOME_TRUNCATED;
                end
              end
            end
          end
          PH_LENGTH: begin
            rl_d     = c_rl | (SW'(b) << {c_idx[2:0], 3'b000});
            idx_d    = idx_new;
            acc_d    = acc_sum;
            sticky_d = acc_sticky;
            if (idx_new >= lsz_q) begin
              idx_d = '0;
              if (osz_q == '0) begin
                do_finish  = 1'b1;
                fin_sparse = 1'b1;
              end else begin
                phase_d = PH_OFFSET;
              end
            end
            if (last && !do_finish) begin
              do_halt   = 1'b1;
              halt_code = ndr_pkg::OUTCOME_TRUNCATED;
            end
          end
          PH_OFFSET: begin
            if (idx_new >= osz_q) begin
              // sign extension of a field shorter than the word
              if (osz_q < FULL_FB && b[7]) begin
                ext = off_new | ({SW{1'b1}} << {osz_q[2:0], 3'b000});
              end
              off_d     = ext;
              rc_d      = c_rc + ext;
              do_finish = 1'b1;
            end else begin
              off_d = off_new;
              idx_d = idx_new;
              if (last) begin
                do_halt   = 1'b1;
                halt_code = ndr_pkg::OUTCOME_TRUNCATED;
              end
            end
          end
          default: ;
        endcase
      end

      if (do_finish) begin
        cov_fin   = sticky_d ? ndr_pkg::COV_MAX : acc_d;
        complete  = cov_fin >= need_q;
        cov_d     = cov_fin;
        stopped_d = complete || last;
        phase_d   = PH_HEADER;
        idx_d     = '0;
        res_valid = 1'b1;
        res_d.run_len         = rl_d;
        res_d.cluster         = rc_d;
        res_d.use_start       = !fin_sparse;
        res_d.is_sparse       = fin_sparse;
        res_d.outcome         = ndr_pkg::OUTCOME_RUN;
        res_d.bitmap_complete = complete;
      end else if (do_halt) begin
        stopped_d = 1'b1;
        phase_d   = PH_HEADER;
        idx_d     = '0;
        res_valid = 1'b1;
        res_d.outcome         = halt_code;
        res_d.bitmap_complete = c_cov >= need_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q     <= '0;
      spc_q     <= ndr_pkg::SPC_RESET;
      need_q    <= '0;
      unit_q    <= UNIT_RESET;
      phase_q   <= PH_HEADER;
      idx_q     <= '0;
      lsz_q     <= '0;
      osz_q     <= '0;
      rl_q      <= '0;
      off_q     <= '0;
      rc_q      <= '0;
      cov_q     <= '0;
      acc_q     <= '0;
      sticky_q  <= 1'b0;
      stopped_q <= 1'b0;
      busy_q    <= 1'b0;
      step_q    <= '0;
    end else begin
      vol_q     <= vol_d;
      spc_q     <= spc_d;
      need_q    <= need_d;
      unit_q    <= unit_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      lsz_q     <= lsz_d;
      osz_q     <= osz_d;
      rl_q      <= rl_d;
      off_q     <= off_d;
      rc_q      <= rc_d;
      cov_q     <= cov_d;
      acc_q     <= acc_d;
      sticky_q  <= sticky_d;
      stopped_q <= stopped_d;
      busy_q    <= busy_d;
      step_q    <= step_d;
    end
  end

  ndr_sector_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept && res_valid),
    .in_ready_o  (calc_ready),
    .in_data_i   (res_d),
    .spc_i       (spc_q),
    .vol_i       (vol_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `NDR_ASSERT_IMPL(a_stop_at_header, stopped_q, phase_q == PH_HEADER && idx_q == '0, "stopped parser left mid-run")
  `NDR_ASSERT_IMPL(a_len_index, phase_q == PH_LENGTH, lsz_q != '0 && lsz_q <= MAX_FB && idx_q < lsz_q, "length index out of field")
  `NDR_ASSERT_IMPL(a_off_index, phase_q == PH_OFFSET, osz_q != '0 && osz_q <= MAX_FB && idx_q < osz_q, "offset index out of field")
  `NDR_ASSERT_IMPL(a_acc_above_cov, phase_q != PH_HEADER && !sticky_q, acc_q >= cov_q, "coverage sum below committed count")

endmodule

@@ hw/rtl/ndr_sector_calc.sv @@
module ndr_sector_calc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ndr_pkg::calc_t                      in_data_i,
  input  logic [ndr_pkg::SPC_W-1:0]           spc_i,
  input  logic [ndr_pkg::VOL_W-1:0]           vol_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ndr_pkg::out_beat_t                  out_data_o
);

  typedef struct packed {
    logic [ndr_pkg::SECTOR_W-1:0] cnt;
    logic [ndr_pkg::SECTOR_W-1:0] rcs;
    logic                         use_start;
    logic                         is_sparse;
    ndr_pkg::outcome_e            outcome;
    logic                         complete;
  } prod_t;

  localparam int unsigned PROD_W = ndr_pkg::SECTOR_W + ndr_pkg::SPC_W;

  logic               a_valid_q, b_valid_q, c_valid_q;
  logic               a_load, b_load, c_load;
  ndr_pkg::calc_t     a_q;
  prod_t              b_q, b_d;
  ndr_pkg::out_beat_t c_q, c_d;
  logic [PROD_W-1:0]  cnt_full, rcs_full;
  logic [PROD_W-1:0]  spc_ext;

  assign c_load     = !c_valid_q || out_ready_i;
  assign b_load     = !b_valid_q || c_load;
  assign a_load     = !a_valid_q || b_load;
  assign in_ready_o = a_load;

  assign spc_ext  = {{ndr_pkg::SECTOR_W{1'b0}}, spc_i};
  assign cnt_full = {{ndr_pkg::SPC_W{1'b0}}, a_q.run_len} * spc_ext;
  assign rcs_full = {{ndr_pkg::SPC_W{1'b0}}, a_q.cluster} * spc_ext;

  always_comb begin
    b_d           = '0;
    b_d.cnt       = cnt_full[ndr_pkg::SECTOR_W-1:0];
    b_d.rcs       = a_q.use_start ? rcs_full[ndr_pkg::SECTOR_W-1:0] : '0;
    b_d.use_start = a_q.use_start;
    b_d.is_sparse = a_q.is_sparse;
    b_d.outcome   = a_q.outcome;
    b_d.complete  = a_q.bitmap_complete;
  end

  always_comb begin
    c_d                  = '0;
    c_d.run_start_sector = b_q.use_start ?
        b_q.rcs + {{(ndr_pkg::SECTOR_W - ndr_pkg::VOL_W){1'b0}}, vol_i} : '0;
    c_d.run_sector_count = b_q.cnt;
    c_d.is_sparse        = b_q.is_sparse;
    c_d.outcome          = b_q.outcome;
    c_d.bitmap_complete  = b_q.complete;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_q <= in_valid_i;
      end
      if (b_load) begin
        b_valid_q <= a_valid_q;
      end
      if (c_load) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load && in_valid_i) begin
      a_q <= in_data_i;
    end
    if (b_load && a_valid_q) begin
      b_q <= b_d;
    end
    if (c_load && b_valid_q) begin
      c_q <= c_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_data_o  = c_q;

endmodule
